@@ hw/rtl/lmx_pkg.sv @@
// ----------------------------------------------------------------------------
// lmx_pkg
// Shared types and constants of the 3x3 local maximum detector.
// ----------------------------------------------------------------------------
package lmx_pkg;

	// Fixed field widths of the stream and register interfaces
	localparam int VALUE_BITS     = 16;
	localparam int COORD_BITS     = 10;
	localparam int CFG_BITS       = 11;
	localparam int APB_ADDR_BITS  = 3;
	localparam int APB_DATA_BITS  = 32;
	localparam int OUT_TDATA_BITS = 40;

	localparam int DEF_MAX_WIDTH   = 1024;
	localparam int DEF_SAMPLE_BITS = 16;

	localparam logic [CFG_BITS-1:0] WIDTH_RESET = 11'd640;

	// Register index (word address bit of paddr)
	localparam logic REG_IMAGE_WIDTH = 1'b0;

	// Input kind codes
	localparam logic KIND_PIXEL = 1'b0;
	localparam logic KIND_PAD   = 1'b1;

	// One result item; is_max sits in the lowest bit when packed
	typedef struct packed {
		logic [VALUE_BITS-1:0] value;
		logic [COORD_BITS-1:0] col;
		logic [COORD_BITS-1:0] row;
		logic                  is_max;
	} res_t;

	// Per-item control for the window compare
	typedef struct packed {
		logic                  top;       // row above lies inside the image
		logic                  bot;       // row below lies inside the image
		logic                  left1;     // column c-1 exists
		logic                  left2;     // column c-2 exists
		logic                  emit0;     // decide pixel (r-1, c-1)
		logic                  emit1;     // decide pixel (r-1, c), row end
		logic [COORD_BITS-1:0] row;       // row of the decided pixels
		logic [COORD_BITS-1:0] col;       // column of the current item
	} win_ctl_t;

endpackage

@@ hw/rtl/local_max_3x3_detector.sv @@
// ----------------------------------------------------------------------------
// local_max_3x3_detector
// Streaming 3x3 regional-maximum test over a raster pixel stream.
// ----------------------------------------------------------------------------
//
//  channel   | group               | payload
//  ----------+---------------------+---------------------------------------
//  pixels in | s_axis_* (stream)   | tdata: pixel_value; tuser: kind
//  results   | m_axis_* (stream)   | tdata: is_max,out_row,out_col,out_value
//            |                     | tlast: out_last
//  config    | APB (psel..pready)  | image_width at byte address 0
//
// One pixel is accepted per cycle while s_axis_tready is high. Line buffers
// are read at the accept edge, the compare runs in the following cycle, and
// a result enters the output register as its item leaves the compare stage.
// Past a frame's first row, a row-end item emits two results, which leave the
// output port in turn. Reset clears counters, window and valid flags; line
// buffers are not cleared. A stalled output holds up to two results and stalls
// the input only when the compare stage also holds a result-bearing item.
// ----------------------------------------------------------------------------
module local_max_3x3_detector #(
	parameter int MAX_WIDTH   = lmx_pkg::DEF_MAX_WIDTH,
	parameter int SAMPLE_BITS = lmx_pkg::DEF_SAMPLE_BITS
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// APB configuration port
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [lmx_pkg::APB_ADDR_BITS-1:0]    paddr,
	input  logic [lmx_pkg::APB_DATA_BITS-1:0]    pwdata,
	output logic [lmx_pkg::APB_DATA_BITS-1:0]    prdata,
	output logic                                 pready,
	// Pixel input
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	input  logic [lmx_pkg::VALUE_BITS-1:0]       s_axis_tdata,  // [15:0] pixel_value
	input  logic [0:0]                           s_axis_tuser,  // [0] kind
	// Result output
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	// [0] is_max, [10:1] out_row, [20:11] out_col, [36:21] out_value, zero above
	output logic [lmx_pkg::OUT_TDATA_BITS-1:0]   m_axis_tdata,
	output logic                                 m_axis_tlast
);

	import lmx_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int WW = (CW + 1 > CFG_BITS) ? CW + 1 : CFG_BITS;
	localparam int PW = (SAMPLE_BITS > VALUE_BITS) ? SAMPLE_BITS : VALUE_BITS;
	localparam logic [WW-1:0] MAX_W = WW'(MAX_WIDTH);
	localparam logic [WW-1:0] MIN_W = WW'(2);

	// Configuration
	logic [CFG_BITS-1:0] width_q;
	logic                cfg_wr;

	// Raster position state
	logic [CW-1:0]         col_q;
	logic [COORD_BITS-1:0] row_q;
	logic [1:0]            seen_q;   // rows since frame start, saturating at 2
	logic                  flush_q;

	// Accept-side decode
	logic                   accept;
	logic [WW-1:0]          w_raw, w_eff, c_ext;
	logic                   last_now, pad_now;
	logic [PW-1:0]          pix_ext;
	logic [SAMPLE_BITS-1:0] v_now;

	// Compare stage
	logic                   s1_valid_q;
	win_ctl_t               ctl_s1;
	logic [CW-1:0]          addr_s1;
	logic [SAMPLE_BITS-1:0] v_s1;
	logic [SAMPLE_BITS-1:0] a_rd, m_rd;
	logic                   adv, has_res, load, out_free;
	res_t                   res0, res1, out_res;

	// ---------------- configuration port ----------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= WIDTH_RESET;
		end else if (cfg_wr && paddr[2] == REG_IMAGE_WIDTH) begin
			width_q <= pwdata[CFG_BITS-1:0];
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_IMAGE_WIDTH: prdata = APB_DATA_BITS'(width_q);
			default:         prdata = '0;
		endcase
	end

	// ---------------- accept side ----------------
	assign accept = s_axis_tvalid && s_axis_tready;

	// Clamp the width into 2..MAX_WIDTH
	always_comb begin
		w_raw = WW'(width_q);
		if (w_raw < MIN_W) begin
			w_eff = MIN_W;
		end else if (w_raw > MAX_W) begin
			w_eff = MAX_W;
		end else begin
			w_eff = w_raw;
		end
		c_ext    = WW'(col_q);
		last_now = c_ext >= (w_eff - WW'(1));
		// Column 0 decides whether the whole row is padding
		pad_now  = (col_q == '0) ? (s_axis_tuser[0] == KIND_PAD) : flush_q;
		pix_ext  = PW'(s_axis_tdata);
		v_now    = pad_now ? '0 : pix_ext[SAMPLE_BITS-1:0];
	end

	// Advance the raster position on every accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			seen_q  <= '0;
			flush_q <= 1'b0;
		end else if (accept) begin
			flush_q <= pad_now;
			if (last_now) begin
				col_q <= '0;
				if (pad_now) begin
					// Flush row done: restart for the next frame
					row_q  <= '0;
					seen_q <= '0;
				end else begin
					row_q <= row_q + COORD_BITS'(1);
					if (seen_q != 2'd2) begin
						seen_q <= seen_q + 2'd1;
					end
				end
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	// Compare stage registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= 1'b1;
		end else if (adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ctl_s1.top   <= seen_q == 2'd2;
			ctl_s1.bot   <= !pad_now;
			ctl_s1.left1 <= col_q != '0;
			ctl_s1.left2 <= col_q > CW'(1);
			ctl_s1.emit0 <= seen_q != 2'd0 && col_q != '0;
			ctl_s1.emit1 <= seen_q != 2'd0 && last_now;
			ctl_s1.row   <= row_q - COORD_BITS'(1);
			ctl_s1.col   <= COORD_BITS'(col_q);
			addr_s1      <= col_q;
			v_s1         <= v_now;
		end
	end

	// ---------------- line buffers ----------------
	// Read at the accept edge; write back as the item leaves the compare stage
	lmx_line_ram #(.DEPTH(MAX_WIDTH), .WIDTH(SAMPLE_BITS)) u_line_above (
		.clk   (clk),
		.we    (adv),
		.waddr (addr_s1),
		.wdata (m_rd),
		.re    (accept),
		.raddr (col_q),
		.rdata (a_rd)
	);

	lmx_line_ram #(.DEPTH(MAX_WIDTH), .WIDTH(SAMPLE_BITS)) u_line_middle (
		.clk   (clk),
		.we    (adv),
		.waddr (addr_s1),
		.wdata (v_s1),
		.re    (accept),
		.raddr (col_q),
		.rdata (m_rd)
	);

	// ---------------- window and compare ----------------
	lmx_window #(.SAMPLE_BITS(SAMPLE_BITS)) u_window (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.ctl    (ctl_s1),
		.a      (a_rd),
		.m      (m_rd),
		.v      (v_s1),
		.res0   (res0),
		.res1   (res1)
	);

	// An item with no result leaves even when the output is full
	assign has_res = ctl_s1.emit0 || ctl_s1.emit1;
	assign adv     = s1_valid_q && (!has_res || out_free);
	assign load    = adv && has_res;

	assign s_axis_tready = !s1_valid_q || adv;

	// ---------------- output register ----------------
	// Result-bearing row-end items carry both results, so emit1 marks the pair
	lmx_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (load),
		.in0       (ctl_s1.emit0 ? res0 : res1),
		.in1       (res1),
		.in1_valid (ctl_s1.emit0 && ctl_s1.emit1),
		.free      (out_free),
		.tvalid    (m_axis_tvalid),
		.tready    (m_axis_tready),
		.tdata     (out_res),
		.tlast     (m_axis_tlast)
	);

	assign m_axis_tdata = OUT_TDATA_BITS'(out_res);

endmodule

@@ hw/rtl/lmx_line_ram.sv @@
// ----------------------------------------------------------------------------
// lmx_line_ram
// One-row line buffer: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module lmx_line_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ hw/rtl/lmx_window.sv @@
// ----------------------------------------------------------------------------
// lmx_window
// Two-column window registers and the neighbour compares for one item.
// ----------------------------------------------------------------------------
module lmx_window #(
	parameter int SAMPLE_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   adv,
	input  lmx_pkg::win_ctl_t      ctl,
	input  logic [SAMPLE_BITS-1:0] a,
	input  logic [SAMPLE_BITS-1:0] m,
	input  logic [SAMPLE_BITS-1:0] v,
	output lmx_pkg::res_t          res0,
	output lmx_pkg::res_t          res1
);

	import lmx_pkg::*;

	localparam int PW = (SAMPLE_BITS > VALUE_BITS) ? SAMPLE_BITS : VALUE_BITS;

	logic [SAMPLE_BITS-1:0] a1_q, m1_q, b1_q, a2_q, m2_q, b2_q;
	logic                   ok0, ok1;
	logic [PW-1:0]          m1_ext, m_ext;

	// Shift the window by one column as the item leaves
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a1_q <= '0;
			m1_q <= '0;
			b1_q <= '0;
			a2_q <= '0;
			m2_q <= '0;
			b2_q <= '0;
		end else if (adv) begin
			a2_q <= a1_q;
			m2_q <= m1_q;
			b2_q <= b1_q;
			a1_q <= a;
			m1_q <= m;
			b1_q <= v;
		end
	end

	always_comb begin
		ok0 = (m1_q >= m)
			&& (!ctl.top || (m1_q >= a1_q && m1_q >= a))
			&& (!ctl.bot || (m1_q >= b1_q && m1_q >= v))
			&& (!ctl.left2 || (m1_q >= m2_q
				&& (!ctl.top || m1_q >= a2_q)
				&& (!ctl.bot || m1_q >= b2_q)));
		ok1 = (!ctl.top || m >= a)
			&& (!ctl.bot || m >= v)
			&& (!ctl.left1 || (m >= m1_q
				&& (!ctl.top || m >= a1_q)
				&& (!ctl.bot || m >= b1_q)));
	end

	assign m1_ext = PW'(m1_q);
	assign m_ext  = PW'(m);

	always_comb begin
		res0.is_max = ok0;
		res0.row    = ctl.row;
		res0.col    = ctl.col - COORD_BITS'(1);
		res0.value  = m1_ext[VALUE_BITS-1:0];
		res1.is_max = ok1;
		res1.row    = ctl.row;
		res1.col    = ctl.col;
		res1.value  = m_ext[VALUE_BITS-1:0];
	end

endmodule

@@ hw/rtl/lmx_out_buf.sv @@
// ----------------------------------------------------------------------------
// lmx_out_buf
// Two-entry result register: holds both results of a row-end item.
// ----------------------------------------------------------------------------
module lmx_out_buf (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          load,
	input  lmx_pkg::res_t in0,
	input  lmx_pkg::res_t in1,
	input  logic          in1_valid,
	output logic          free,
	output logic          tvalid,
	input  logic          tready,
	output lmx_pkg::res_t tdata,
	output logic          tlast
);

	import lmx_pkg::*;

	res_t e0_q, e1_q;
	logic v0_q, v1_q;
	logic take;

	assign take   = v0_q && tready;
	assign free   = !v0_q || (!v1_q && take);
	assign tvalid = v0_q;
	assign tdata  = e0_q;
	// Head is last unless its partner waits behind it
	assign tlast  = !v1_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v0_q <= 1'b0;
			v1_q <= 1'b0;
		end else if (load) begin
			v0_q <= 1'b1;
			v1_q <= in1_valid;
		end else if (take) begin
			v0_q <= v1_q;
			v1_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			e0_q <= in0;
			e1_q <= in1;
		end else if (take) begin
			e0_q <= e1_q;
		end
	end

endmodule

@@ hw/rtl/lmx_checker.sv @@
// ----------------------------------------------------------------------------
// lmx_checker
// Port-level checks of the 3x3 local maximum detector, bound to its top.
// ----------------------------------------------------------------------------
module lmx_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               psel,
	input logic                               penable,
	input logic                               pwrite,
	input logic [lmx_pkg::APB_ADDR_BITS-1:0]  paddr,
	input logic [lmx_pkg::APB_DATA_BITS-1:0]  pwdata,
	input logic [lmx_pkg::APB_DATA_BITS-1:0]  prdata,
	input logic                               pready,
	input logic                               m_axis_tvalid,
	input logic                               m_axis_tready,
	input logic [lmx_pkg::OUT_TDATA_BITS-1:0] m_axis_tdata,
	input logic                               m_axis_tlast
);

	import lmx_pkg::*;

	logic out_take;
	logic cfg_wr0;

	assign out_take = m_axis_tvalid && m_axis_tready;
	assign cfg_wr0  = psel && penable && pwrite && pready
		&& paddr[2] == REG_IMAGE_WIDTH;

	// Hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled result changed");

	// The first of a row-end pair is followed at once by its partner
	a_pair_follows: assert property (@(posedge clk) disable iff (!arst_n)
		out_take && !m_axis_tlast |=> m_axis_tvalid)
		else $error("partner result missing");

	// The partner is the next column of the same row
	a_pair_coord: assert property (@(posedge clk) disable iff (!arst_n)
		out_take && !m_axis_tlast |=>
			m_axis_tdata[20:11] == $past(m_axis_tdata[20:11]) + COORD_BITS'(1)
			&& m_axis_tdata[10:1] == $past(m_axis_tdata[10:1]))
		else $error("partner coordinates wrong");

	// A written width reads back
	a_cfg_readback: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr0 |=> paddr[2] != REG_IMAGE_WIDTH
			|| prdata[CFG_BITS-1:0] == $past(pwdata[CFG_BITS-1:0]))
		else $error("image width readback mismatch");

endmodule

bind local_max_3x3_detector lmx_checker u_lmx_checker (.*);
